// ----- hdl/prd_pkg.sv -----
// ----------------------------------------------------------------------------
// Packet record deframer package
// Shared types and constants for the record deframer core.
// ----------------------------------------------------------------------------
package prd_pkg;

    localparam int HDR_LEN = 48;
    localparam int POS_W   = $clog2(HDR_LEN);
    localparam int CNT_W   = 63;

    // magic 0x50475244, stored little endian
    localparam logic [31:0] REC_MAGIC   = 32'h5047_5244;
    localparam logic [15:0] REC_VERSION = 16'd1;
    localparam logic [15:0] REC_HDR_LEN = 16'd48;

    localparam logic [15:0] CODEC0_RESET = 16'd1;
    localparam logic [15:0] CODEC1_RESET = 16'd2;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_EOF  = 1'b1
    } opcode_t;

    typedef enum logic {
        REG_FIRST_CODEC  = 1'b0,
        REG_SECOND_CODEC = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        KIND_RECORD   = 3'd0,
        KIND_SUMMARY  = 3'd1,
        KIND_BAD_HDR  = 3'd2,
        KIND_OVERSIZE = 3'd3,
        KIND_BAD_META = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [CNT_W-1:0]   record_offset;
        logic [CNT_W-1:0]   payload_length;
        logic [31:0]        track_number;
        logic [15:0]        codec_code;
        logic [15:0]        flag_bits;
        logic [63:0]        presentation_time;
        logic [63:0]        decode_time;
        logic [63:0]        duration_time;
        logic [CNT_W-1:0]   recovered_length;
        logic [CNT_W-1:0]   trailing_length;
        logic [CNT_W-1:0]   record_total;
    } result_t;

endpackage

// ----- hdl/packet_record_deframer_core.sv -----
// ----------------------------------------------------------------------------
// Packet record deframer core
// Splits a packet record byte stream into index, error and summary results.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat is a file byte (opcode 0) or an
// end-of-file marker (opcode 1). Output channel (out_valid/out_ready): one beat
// per result. A result is registered in the cycle after the beat that causes it: the
// last header byte of a bad, oversized or empty-payload record, the last
// payload byte of a record, or the end-of-file beat.
// Throughput is one input beat per cycle while in_ready is high; the work for a
// beat is done in the cycle it is taken and lands in the single output register.
// in_ready drops only while the output register holds a result that the
// receiver is stalling; a free or draining output register keeps input flowing.
// The 48 header bytes go through a shift line and sit at fixed taps once the
// header is complete, where they stay until the payload is done.
// Reset clears the parse state and counters and loads the codec registers with
// 1 and 2. After an error result the core drops bytes (still counting them)
// until end of file; the summary beat also clears the stream state.
// wr_en/wr_index/wr_data write a codec register in the cycle wr_en is high.
// ----------------------------------------------------------------------------
module packet_record_deframer_core
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                wr_en,
    input  logic                wr_index,
    input  logic [15:0]         wr_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic [7:0]          data_byte,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          result_kind,
    output logic [62:0]         record_offset,
    output logic [62:0]         payload_length,
    output logic [31:0]         track_number,
    output logic [15:0]         codec_code,
    output logic [15:0]         flag_bits,
    output logic signed [63:0]  presentation_time,
    output logic signed [63:0]  decode_time,
    output logic signed [63:0]  duration_time,
    output logic [62:0]         recovered_length,
    output logic [62:0]         trailing_length,
    output logic [62:0]         record_total
);

    localparam int HL   = prd_pkg::HDR_LEN;
    localparam int PW   = prd_pkg::POS_W;
    localparam int CW   = prd_pkg::CNT_W;

    logic [15:0]            codec0_reg;
    logic [15:0]            codec1_reg;

    prd_pkg::phase_t        phase_reg, phase_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [7:0]             hdr_reg [HL];
    logic [7:0]             hdr_view [HL];
    logic [CW-1:0]          remain_reg, remain_next;
    logic [CW-1:0]          offset_reg, offset_next;
    logic [CW-1:0]          start_reg, start_next;
    logic [CW-1:0]          recov_reg, recov_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   meta_bad_reg, meta_bad_next;

    logic                   out_valid_reg;
    prd_pkg::result_t       out_reg;
    prd_pkg::result_t       res;
    logic                   res_valid;

    logic                   in_fire;
    logic                   is_byte;
    logic                   shift_en;

    logic [31:0]            f_magic;
    logic [15:0]            f_version;
    logic [15:0]            f_hlen;
    logic [31:0]            f_track;
    logic [15:0]            f_codec;
    logic [15:0]            f_flags;
    logic [63:0]            f_pts;
    logic [63:0]            f_dts;
    logic [63:0]            f_dur;
    logic [63:0]            f_plen;
    logic                   meta_bad_now;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_byte  = (prd_pkg::opcode_t'(opcode) == prd_pkg::OP_BYTE);
    assign shift_en = in_fire && is_byte && (phase_reg == prd_pkg::PH_HEADER);

    // header as it stands after this beat; byte i of the header at tap i
    always_comb
    begin
        for (int i = 0; i < HL; i++)
        begin
            if (!shift_en)
                hdr_view[i] = hdr_reg[i];
            else if (i == HL - 1)
                hdr_view[i] = data_byte;
            else
                hdr_view[i] = hdr_reg[i + 1];
        end
    end

    assign f_magic   = {hdr_view[3], hdr_view[2], hdr_view[1], hdr_view[0]};
    assign f_version = {hdr_view[5], hdr_view[4]};
    assign f_hlen    = {hdr_view[7], hdr_view[6]};
    assign f_track   = {hdr_view[11], hdr_view[10], hdr_view[9], hdr_view[8]};
    assign f_codec   = {hdr_view[13], hdr_view[12]};
    assign f_flags   = {hdr_view[15], hdr_view[14]};
    assign f_pts     = {hdr_view[23], hdr_view[22], hdr_view[21], hdr_view[20],
                        hdr_view[19], hdr_view[18], hdr_view[17], hdr_view[16]};
    assign f_dts     = {hdr_view[31], hdr_view[30], hdr_view[29], hdr_view[28],
                        hdr_view[27], hdr_view[26], hdr_view[25], hdr_view[24]};
    assign f_dur     = {hdr_view[39], hdr_view[38], hdr_view[37], hdr_view[36],
                        hdr_view[35], hdr_view[34], hdr_view[33], hdr_view[32]};
    assign f_plen    = {hdr_view[47], hdr_view[46], hdr_view[45], hdr_view[44],
                        hdr_view[43], hdr_view[42], hdr_view[41], hdr_view[40]};

    assign meta_bad_now = (f_track == 32'd0) ||
                          ((f_codec != codec0_reg) && (f_codec != codec1_reg));

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec0_reg <= prd_pkg::CODEC0_RESET;
            codec1_reg <= prd_pkg::CODEC1_RESET;
        end
        else if (wr_en)
        begin
            unique case (prd_pkg::reg_index_t'(wr_index))
                prd_pkg::REG_FIRST_CODEC:  codec0_reg <= wr_data;
                prd_pkg::REG_SECOND_CODEC: codec1_reg <= wr_data;
                default:                   codec0_reg <= codec0_reg;
            endcase
        end
    end

    // next state and result
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        remain_next   = remain_reg;
        offset_next   = offset_reg;
        start_next    = start_reg;
        recov_next    = recov_reg;
        count_next    = count_reg;
        meta_bad_next = meta_bad_reg;
        res_valid     = 1'b0;

        res                   = '0;
        res.kind              = prd_pkg::KIND_RECORD;
        res.record_offset     = start_reg;
        res.payload_length    = f_plen[CW-1:0];
        res.track_number      = f_track;
        res.codec_code        = f_codec;
        res.flag_bits         = f_flags;
        res.presentation_time = f_pts;
        res.decode_time       = f_dts;
        res.duration_time     = f_dur;

        if (in_fire && !is_byte)
        begin
            res                  = '0;
            res.kind             = prd_pkg::KIND_SUMMARY;
            res.recovered_length = recov_reg;
            res.trailing_length  = offset_reg - recov_reg;
            res.record_total     = count_reg;
            res_valid            = 1'b1;
            phase_next           = prd_pkg::PH_HEADER;
            pos_next             = '0;
            remain_next          = '0;
            offset_next          = '0;
            start_next           = '0;
            recov_next           = '0;
            count_next           = '0;
            meta_bad_next        = 1'b0;
        end
        else if (in_fire)
        begin
            offset_next = offset_reg + CW'(1);
            unique case (phase_reg)
                prd_pkg::PH_HEADER:
                begin
                    if (pos_reg != PW'(HL - 1))
                        pos_next = pos_reg + PW'(1);
                    else
                    begin
                        pos_next  = '0;
                        res_valid = 1'b1;
                        if (f_magic != prd_pkg::REC_MAGIC ||
                            f_version != prd_pkg::REC_VERSION ||
                            f_hlen != prd_pkg::REC_HDR_LEN)
                        begin
                            res.kind   = prd_pkg::KIND_BAD_HDR;
                            phase_next = prd_pkg::PH_HALTED;
                        end
                        else if (f_plen[63])
                        begin
                            res.kind   = prd_pkg::KIND_OVERSIZE;
                            phase_next = prd_pkg::PH_HALTED;
                        end
                        else
                        begin
                            meta_bad_next = meta_bad_now;
                            if (f_plen[CW-1:0] != '0)
                            begin
                                res_valid   = 1'b0;
                                remain_next = f_plen[CW-1:0];
                                phase_next  = prd_pkg::PH_PAYLOAD;
                            end
                            else if (meta_bad_now)
                            begin
                                res.kind   = prd_pkg::KIND_BAD_META;
                                phase_next = prd_pkg::PH_HALTED;
                            end
                            else
                            begin
                                recov_next = offset_next;
                                start_next = offset_next;
                                count_next = count_reg + CW'(1);
                                phase_next = prd_pkg::PH_HEADER;
                            end
                        end
                    end
                end
                prd_pkg::PH_PAYLOAD:
                begin
                    remain_next = remain_reg - CW'(1);
                    if (remain_reg == CW'(1))
                    begin
                        res_valid = 1'b1;
                        if (meta_bad_reg)
                        begin
                            res.kind   = prd_pkg::KIND_BAD_META;
                            phase_next = prd_pkg::PH_HALTED;
                        end
                        else
                        begin
                            recov_next = offset_next;
                            start_next = offset_next;
                            count_next = count_reg + CW'(1);
                            pos_next   = '0;
                            phase_next = prd_pkg::PH_HEADER;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= prd_pkg::PH_HEADER;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            remain_reg   <= '0;
            offset_reg   <= '0;
            start_reg    <= '0;
            recov_reg    <= '0;
            count_reg    <= '0;
            meta_bad_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            remain_reg   <= remain_next;
            offset_reg   <= offset_next;
            start_reg    <= start_next;
            recov_reg    <= recov_next;
            count_reg    <= count_next;
            meta_bad_reg <= meta_bad_next;
        end
    end

    // header shift line, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HL; i++)
            hdr_reg[i] <= hdr_view[i];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
            out_reg <= res;
    end

    assign out_valid         = out_valid_reg;
    assign result_kind       = out_reg.kind;
    assign record_offset     = out_reg.record_offset;
    assign payload_length    = out_reg.payload_length;
    assign track_number      = out_reg.track_number;
    assign codec_code        = out_reg.codec_code;
    assign flag_bits         = out_reg.flag_bits;
    assign presentation_time = out_reg.presentation_time;
    assign decode_time       = out_reg.decode_time;
    assign duration_time     = out_reg.duration_time;
    assign recovered_length  = out_reg.recovered_length;
    assign trailing_length   = out_reg.trailing_length;
    assign record_total      = out_reg.record_total;

endmodule

// ----- tb/sv/prd_record_tracker_pkg.sv -----
// ----------------------------------------------------------------------------
// Record tracker for the packet record deframer testbench
// Keeps its own copy of the parse state, works out the result each accepted
// beat should cause, and checks the results the core hands out in order.
// ----------------------------------------------------------------------------
package prd_record_tracker_pkg;

    import prd_pkg::*;

    class record_tracker;

        // codec registers as last written
        logic [15:0]  codec_a = CODEC0_RESET;
        logic [15:0]  codec_b = CODEC1_RESET;

        // parse state
        phase_t       phase = PH_HEADER;
        int           hdr_pos = 0;
        logic [383:0] hdr = '0;
        logic [63:0]  payload_left = '0;
        logic [63:0]  byte_offset = '0;
        logic [63:0]  rec_start = '0;
        logic [63:0]  recovered_end = '0;
        logic [63:0]  rec_count = '0;
        logic         meta_bad = 1'b0;

        result_t      due_results[$];

        int           mismatches = 0;
        int           beats = 0;
        int           live_beats = 0;
        int           results_due = 0;
        int           results_seen = 0;

        function void set_codecs(logic [15:0] a, logic [15:0] b);
            codec_a = a;
            codec_b = b;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void restart_file();
            phase         = PH_HEADER;
            hdr_pos       = 0;
            hdr           = '0;
            payload_left  = '0;
            byte_offset   = '0;
            rec_start     = '0;
            recovered_end = '0;
            rec_count     = '0;
            meta_bad      = 1'b0;
        endfunction

        function void push_result(result_t r);
            due_results = {due_results, r};
            results_due++;
        endfunction

        // header fields and record start copied into a result, other counters left at zero
        function result_t header_result(kind_t k);
            result_t r;
            r                   = '0;
            r.kind              = k;
            r.record_offset     = rec_start[62:0];
            r.payload_length    = hdr[320 +: 63];
            r.track_number      = hdr[64 +: 32];
            r.codec_code        = hdr[96 +: 16];
            r.flag_bits         = hdr[112 +: 16];
            r.presentation_time = hdr[128 +: 64];
            r.decode_time       = hdr[192 +: 64];
            r.duration_time     = hdr[256 +: 64];
            return r;
        endfunction

        function void close_record();
            if (meta_bad)
            begin
                push_result(header_result(KIND_BAD_META));
                phase = PH_HALTED;
            end
            else
            begin
                push_result(header_result(KIND_RECORD));
                recovered_end = byte_offset;
                rec_count     = rec_count + 1;
                rec_start     = byte_offset;
                phase         = PH_HEADER;
            end
        endfunction

        function void take_beat(opcode_t op, logic [7:0] b);
            result_t r;
            beats++;
            if (op == OP_EOF || phase == PH_HEADER || phase == PH_PAYLOAD)
                live_beats++;
            if (op == OP_EOF)
            begin
                r                  = '0;
                r.kind             = KIND_SUMMARY;
                r.recovered_length = recovered_end[62:0];
                r.trailing_length  = 63'(byte_offset - recovered_end);
                r.record_total     = rec_count[62:0];
                push_result(r);
                restart_file();
                return;
            end
            byte_offset = byte_offset + 1;
            if (phase == PH_HEADER)
            begin
                hdr[8*hdr_pos +: 8] = b;
                hdr_pos++;
                if (hdr_pos < HDR_LEN)
                    return;
                hdr_pos = 0;
                if (hdr[0 +: 32] != REC_MAGIC || hdr[32 +: 16] != REC_VERSION ||
                    hdr[48 +: 16] != REC_HDR_LEN)
                begin
                    push_result(header_result(KIND_BAD_HDR));
                    phase = PH_HALTED;
                end
                else if (hdr[383])
                begin
                    push_result(header_result(KIND_OVERSIZE));
                    phase = PH_HALTED;
                end
                else
                begin
                    meta_bad = (hdr[64 +: 32] == 32'd0) ||
                               (hdr[96 +: 16] != codec_a && hdr[96 +: 16] != codec_b);
                    if (hdr[320 +: 64] == 64'd0)
                        close_record();
                    else
                    begin
                        payload_left = hdr[320 +: 64];
                        phase        = PH_PAYLOAD;
                    end
                end
            end
            else if (phase == PH_PAYLOAD)
            begin
                payload_left = payload_left - 1;
                if (payload_left == 64'd0)
                    close_record();
            end
        endfunction

        task report(string what);
            $display("%0t MISMATCH: %s", $time, what);
            mismatches++;
        endtask

        task cmp(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %h, want %h",
                                 results_seen, name, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("result %0d of kind %0d with none due",
                                 results_seen, got.kind));
                results_seen++;
                return;
            end
            want = due_results[0];
            due_results.delete(0);
            cmp("result_kind", got.kind, want.kind);
            cmp("record_offset", got.record_offset, want.record_offset);
            cmp("payload_length", got.payload_length, want.payload_length);
            cmp("track_number", got.track_number, want.track_number);
            cmp("codec_code", got.codec_code, want.codec_code);
            cmp("flag_bits", got.flag_bits, want.flag_bits);
            cmp("presentation_time", got.presentation_time, want.presentation_time);
            cmp("decode_time", got.decode_time, want.decode_time);
            cmp("duration_time", got.duration_time, want.duration_time);
            cmp("recovered_length", got.recovered_length, want.recovered_length);
            cmp("trailing_length", got.trailing_length, want.trailing_length);
            cmp("record_total", got.record_total, want.record_total);
            results_seen++;
        endtask

    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Packet record deframer testbench
// Streams record files byte by byte into the core: directed edge cases first,
// then random files of good, broken and truncated records under several codec
// settings, with random stalls on both channels. Every result is checked
// against the record tracker's prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import prd_pkg::*;
    import prd_record_tracker_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [63:0] plen;
        logic [63:0] dur;
        logic [63:0] dts;
        logic [63:0] pts;
        logic [15:0] flags;
        logic [15:0] codec;
        logic [31:0] track;
        logic [15:0] hsize;
        logic [15:0] version;
        logic [31:0] magic;
    } rec_header_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic        wr_index = 1'b0;
    logic [15:0] wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;

    logic [2:0]         result_kind;
    logic [62:0]        record_offset;
    logic [62:0]        payload_length;
    logic [31:0]        track_number;
    logic [15:0]        codec_code;
    logic [15:0]        flag_bits;
    logic signed [63:0] presentation_time;
    logic signed [63:0] decode_time;
    logic signed [63:0] duration_time;
    logic [62:0]        recovered_length;
    logic [62:0]        trailing_length;
    logic [62:0]        record_total;

    logic        calm = 1'b0;
    int          files = 0;
    int          codec_settings = 1;

    record_tracker tracker = new();

    packet_record_deframer_core u_top
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .wr_en             (wr_en),
        .wr_index          (wr_index),
        .wr_data           (wr_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .result_kind       (result_kind),
        .record_offset     (record_offset),
        .payload_length    (payload_length),
        .track_number      (track_number),
        .codec_code        (codec_code),
        .flag_bits         (flag_bits),
        .presentation_time (presentation_time),
        .decode_time       (decode_time),
        .duration_time     (duration_time),
        .recovered_length  (recovered_length),
        .trailing_length   (trailing_length),
        .record_total      (record_total)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d results still due",
                 CYCLE_LIMIT, tracker.pending());
        $display("Verification failed");
        $finish;
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 9);
    end

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.kind              = kind_t'(result_kind);
            got.record_offset     = record_offset;
            got.payload_length    = payload_length;
            got.track_number      = track_number;
            got.codec_code        = codec_code;
            got.flag_bits         = flag_bits;
            got.presentation_time = presentation_time;
            got.decode_time       = decode_time;
            got.duration_time     = duration_time;
            got.recovered_length  = recovered_length;
            got.trailing_length   = trailing_length;
            got.record_total      = record_total;
            tracker.check_result(got);
        end
    end

    // called just after a falling edge; returns at the falling edge after the beat
    task automatic send_beat(input opcode_t op, input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_beat(op, b);
        @(negedge clk);
    endtask

    task automatic end_file();
        send_beat(OP_EOF, 8'($urandom));
        files++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        // margin for the output register and a beat still in flight
        repeat (4) @(negedge clk);
    endtask

    task automatic write_codecs(input logic [15:0] a, input logic [15:0] b);
        wr_en    <= 1'b1;
        wr_index <= REG_FIRST_CODEC;
        wr_data  <= a;
        @(negedge clk);
        wr_index <= REG_SECOND_CODEC;
        wr_data  <= b;
        @(negedge clk);
        wr_en    <= 1'b0;
        tracker.set_codecs(a, b);
        codec_settings++;
    endtask

    task automatic send_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_beat(OP_BYTE, 8'($urandom));
    endtask

    // first n_hdr header bytes, then n_pay random payload bytes
    task automatic send_record(input rec_header_t h, input int n_hdr, input int n_pay);
        logic [383:0] v;
        v = h;
        for (int i = 0; i < n_hdr; i++)
            send_beat(OP_BYTE, v[8*i +: 8]);
        send_bytes(n_pay);
    endtask

    function automatic rec_header_t good_header(input int max_pay);
        rec_header_t h;
        h.magic   = REC_MAGIC;
        h.version = REC_VERSION;
        h.hsize   = REC_HDR_LEN;
        h.track   = $urandom;
        if (h.track == 32'd0)
            h.track = 32'd1;
        h.codec   = $urandom_range(0, 1) ? tracker.codec_a : tracker.codec_b;
        h.flags   = 16'($urandom);
        h.pts     = {$urandom, $urandom};
        h.dts     = {$urandom, $urandom};
        h.dur     = {$urandom, $urandom};
        h.plen    = 64'($urandom_range(0, max_pay));
        return h;
    endfunction

    function automatic logic [15:0] foreign_codec();
        logic [15:0] c;
        do
            c = 16'($urandom);
        while (c == tracker.codec_a || c == tracker.codec_b);
        return c;
    endfunction

    function automatic rec_header_t bad_header(input rec_header_t h);
        case ($urandom_range(0, 2))
            0: h.magic = h.magic ^ (32'd1 << $urandom_range(0, 31));
            1: h.version = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(2, 65535));
            default: h.hsize = h.hsize ^ (16'd1 << $urandom_range(0, 15));
        endcase
        return h;
    endfunction

    task automatic directed_files();
        rec_header_t h;

        // summary on an empty file
        end_file();

        // extreme fields, empty payload; short payload; track zero caught at the end
        h = good_header(0);
        h.track = '1;
        h.codec = tracker.codec_a;
        h.flags = '1;
        h.pts   = 64'h8000_0000_0000_0000;
        h.dts   = 64'h7FFF_FFFF_FFFF_FFFF;
        h.dur   = '1;
        h.plen  = '0;
        send_record(h, HDR_LEN, 0);
        h = good_header(0);
        h.codec = tracker.codec_b;
        h.flags = '0;
        h.pts   = '0;
        h.dts   = '0;
        h.dur   = '0;
        h.plen  = 64'd3;
        send_record(h, HDR_LEN, 3);
        h = good_header(0);
        h.track = '0;
        h.plen  = 64'd2;
        send_record(h, HDR_LEN, 2);
        send_bytes(3);
        end_file();

        // bad magic after a good record, then ignored bytes
        send_record(good_header(0), HDR_LEN, 0);
        h = good_header(4);
        h.magic = ~REC_MAGIC;
        send_record(h, HDR_LEN, 0);
        send_bytes(2);
        end_file();

        h = good_header(0);
        h.version = '1;
        send_record(h, HDR_LEN, 0);
        end_file();

        h = good_header(0);
        h.hsize = '0;
        send_record(h, HDR_LEN, 0);
        end_file();

        // oversized payload
        h = good_header(0);
        h.plen = '1;
        send_record(h, HDR_LEN, 0);
        end_file();

        // largest legal length: the payload is cut short by end of file
        h = good_header(0);
        h.plen = 64'h7FFF_FFFF_FFFF_FFFF;
        send_record(h, HDR_LEN, 5);
        end_file();

        // truncated header
        h = good_header(2);
        send_record(h, HDR_LEN, int'(h.plen));
        send_record(good_header(0), 20, 0);
        end_file();

        // unknown codec with empty payload fails on the last header byte
        h = good_header(0);
        h.codec = foreign_codec();
        h.plen  = '0;
        send_record(h, HDR_LEN, 0);
        end_file();

        // codec registers at the extremes
        drain();
        write_codecs(16'h0000, 16'hFFFF);
        h = good_header(0);
        h.codec = 16'h0000;
        h.plen  = 64'd1;
        send_record(h, HDR_LEN, 1);
        h.codec = 16'hFFFF;
        send_record(h, HDR_LEN, 1);
        h.codec = CODEC0_RESET;
        send_record(h, HDR_LEN, 1);
        end_file();
    endtask

    task automatic random_file();
        rec_header_t h;
        int          n_rec;
        int          pick;
        int          cut;
        bit          stop;
        n_rec = $urandom_range(1, 6);
        stop  = 1'b0;
        for (int i = 0; i < n_rec && !stop; i++)
        begin
            pick = $urandom_range(0, 99);
            h = good_header(($urandom_range(0, 19) == 0) ? 200 : 16);
            if (pick < 62)
            begin
                send_record(h, HDR_LEN, int'(h.plen));
            end
            else if (pick < 68)
            begin
                send_record(bad_header(h), HDR_LEN, 0);
                stop = 1'b1;
            end
            else if (pick < 73)
            begin
                h.plen[63] = 1'b1;
                h.plen[62:0] = 63'({$urandom, $urandom});
                send_record(h, HDR_LEN, 0);
                stop = 1'b1;
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1))
                    h.track = '0;
                else
                    h.codec = foreign_codec();
                send_record(h, HDR_LEN, int'(h.plen));
                stop = 1'b1;
            end
            else if (pick < 86)
            begin
                send_record(h, $urandom_range(1, HDR_LEN - 1), 0);
                stop = 1'b1;
            end
            else if (pick < 92)
            begin
                // payload cut short, now and then with a huge length
                if ($urandom_range(0, 3) == 0)
                    h.plen = {1'b0, 31'($urandom), $urandom};
                else
                    h.plen = 64'($urandom_range(2, 40));
                cut = $urandom_range(0, 10);
                if (h.plen <= 64'(cut))
                    cut = int'(h.plen) - 1;
                send_record(h, HDR_LEN, cut);
                stop = 1'b1;
            end
            else if (pick < 96)
            begin
                send_bytes($urandom_range(1, 60));
                stop = 1'b1;
            end
            else
            begin
                h.plen = '0;
                send_record(h, HDR_LEN, 0);
            end
            if (stop)
                send_bytes($urandom_range(0, 5));
            else if ($urandom_range(0, 49) == 0)
                drain();
        end
        end_file();
    endtask

    task automatic new_codec_setting();
        logic [15:0] v;
        v = 16'($urandom);
        drain();
        case ($urandom_range(0, 4))
            0: write_codecs(16'h0000, 16'hFFFF);
            1: write_codecs(16'hFFFF, 16'h0000);
            2: write_codecs(v, 16'($urandom));
            3: write_codecs(v, v);
            default: write_codecs(CODEC0_RESET, CODEC1_RESET);
        endcase
    endtask

    initial
    begin : stimulus
        int n;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_files();

        drain();
        write_codecs(CODEC0_RESET, CODEC1_RESET);
        n = 0;
        while (tracker.beats < 1100 && n < 400)
        begin
            // first two random files run with no idling on either side
            calm = (n < 2);
            if (n % 2 == 1)
                new_codec_setting();
            random_file();
            n++;
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Streamed %0d beats (%0d parsed) in %0d files under %0d codec settings",
                 tracker.beats, tracker.live_beats, files, codec_settings);
        $display("Checked %0d results, %0d mismatches",
                 tracker.results_seen, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
